### rtl/lndc_pkg.sv
// shared constants and types for the nine-digit id check pipeline
`default_nettype none

package lndc_pkg;

  localparam int unsigned LNDC_NUM_W       = 30;
  localparam int unsigned LNDC_DIGIT_W     = 4;
  localparam int unsigned LNDC_DIGIT_COUNT = 9;

  // floor(x / 10) == (x * RECIP) >> SHIFT for every x below 2^32
  localparam logic [31:0] LNDC_RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned LNDC_RECIP_SHIFT = 35;
  localparam int unsigned LNDC_PROD_W = LNDC_NUM_W + 32;

  localparam logic [LNDC_NUM_W-1:0] LNDC_LOWEST_RST  = 30'd100000000;
  localparam logic [LNDC_NUM_W-1:0] LNDC_HIGHEST_RST = 30'd999999999;

  localparam int unsigned LNDC_CFG_IDX_W = 1;
  localparam logic [LNDC_CFG_IDX_W-1:0] LNDC_CFG_LOWEST  = 1'd0;
  localparam logic [LNDC_CFG_IDX_W-1:0] LNDC_CFG_HIGHEST = 1'd1;

  // what travels from cell to cell
  typedef struct packed {
    logic [LNDC_NUM_W-1:0]   rest;  // digits not yet taken off
    logic [LNDC_DIGIT_W-1:0] sum;   // running sum mod 10
    logic [LNDC_DIGIT_W-1:0] chk;   // check digit of the request
    logic                    oor;   // outside range registers
  } lndc_item_t;

endpackage

`default_nettype wire

### rtl/lndc_cell.sv
// digit cell: strips the lowest decimal digit into sum, or into chk at POS 0
`default_nettype none

module lndc_cell
  import lndc_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  lndc_item_t      item_i,
  output logic            ready_o,
  output logic            valid_o,
  output lndc_item_t      item_o,
  input  wire logic       ready_i
);

  logic                    valid_q;
  lndc_item_t              item_q;
  lndc_item_t              item_d;
  logic [LNDC_PROD_W-1:0]  prod;
  logic [LNDC_NUM_W-1:0]   quot;
  logic [LNDC_DIGIT_W-1:0] tenq_lo;
  logic [LNDC_DIGIT_W-1:0] digit;
  logic [LNDC_DIGIT_W:0]   dbl;
  logic [LNDC_DIGIT_W-1:0] term;
  logic [LNDC_DIGIT_W:0]   acc;

  assign prod    = LNDC_PROD_W'(item_i.rest) * LNDC_PROD_W'(LNDC_RECIP10);
  assign quot    = LNDC_NUM_W'(prod >> LNDC_RECIP_SHIFT);
  // only the low nibble of rest - 10*quot matters, the digit is below ten
  assign tenq_lo = LNDC_DIGIT_W'({quot[3:0], 3'b000} + {3'b000, quot[3:0], 1'b0});
  assign digit   = item_i.rest[LNDC_DIGIT_W-1:0] - tenq_lo;

  always_comb begin
    dbl = {digit, 1'b0};
    if (dbl >= 5'd10) begin
      dbl = dbl - 5'd9;
    end
    if ((POS % 2) == 1) begin
      term = dbl[LNDC_DIGIT_W-1:0];
    end else begin
      term = digit;
    end
    acc = {1'b0, item_i.sum} + {1'b0, term};
    if (acc >= 5'd10) begin
      acc = acc - 5'd10;
    end
    item_d      = item_i;
    item_d.rest = quot;
    if (POS == 0) begin
      item_d.chk = digit;
    end else begin
      item_d.sum = acc[LNDC_DIGIT_W-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### rtl/luhn_nine_digit_id_check.sv
// top level of the mod 10 id check: range check, digit cell chain, result register
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  in       | in_valid_i / in_stall_o  | candidate_number_i
//  out      | out_valid_o / out_stall_i| number_valid_o, out_of_range_o, expected_digit_o
//  cfg      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// one request per cycle while the output is not stalled; the stages are the input register
// with the range compare, one cell per decimal digit, then the result register.
// reset empties every stage and loads the range registers with 100000000 and
// 999999999. a stalled output holds its result while empty stages further up
// keep taking requests; the chain fills and then stalls the input.
`default_nettype none

module luhn_nine_digit_id_check
  import lndc_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = LNDC_DIGIT_COUNT
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [LNDC_CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LNDC_NUM_W-1:0]     cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [LNDC_NUM_W-1:0]     candidate_number_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           number_valid_o,
  output logic                           out_of_range_o,
  output logic [LNDC_DIGIT_W-1:0]        expected_digit_o
);

  logic [LNDC_NUM_W-1:0] lowest_q;
  logic [LNDC_NUM_W-1:0] highest_q;

  logic       s_valid [DIGIT_COUNT+1];
  lndc_item_t s_item  [DIGIT_COUNT+1];
  logic       s_ready [DIGIT_COUNT+1];

  logic       in_valid_q;
  lndc_item_t in_item_q;
  lndc_item_t in_item_d;
  logic       in_ready;

  logic                    out_valid_q;
  logic                    number_valid_q;
  logic                    out_of_range_q;
  logic [LNDC_DIGIT_W-1:0] expected_digit_q;
  logic [LNDC_DIGIT_W-1:0] expect_d;
  logic                    out_ready;

  // range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= LNDC_LOWEST_RST;
      highest_q <= LNDC_HIGHEST_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        LNDC_CFG_LOWEST:  lowest_q  <= cfg_data_i;
        LNDC_CFG_HIGHEST: highest_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register with range compare
  always_comb begin
    in_item_d.rest = candidate_number_i;
    in_item_d.sum  = '0;
    in_item_d.chk  = '0;
    in_item_d.oor  = (candidate_number_i < lowest_q) || (candidate_number_i > highest_q);
  end

  assign in_ready   = !in_valid_q || s_ready[0];
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_item_q <= in_item_d;
    end
  end

  assign s_valid[0] = in_valid_q;
  assign s_item[0]  = in_item_q;

  // digit cells, check digit first
  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
    lndc_cell #(
      .POS(k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s_valid[k]),
      .item_i  (s_item[k]),
      .ready_o (s_ready[k]),
      .valid_o (s_valid[k+1]),
      .item_o  (s_item[k+1]),
      .ready_i (s_ready[k+1])
    );
  end

  // result register
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s_ready[DIGIT_COUNT] = out_ready;

  always_comb begin
    if (s_item[DIGIT_COUNT].sum == '0) begin
      expect_d = '0;
    end else begin
      expect_d = LNDC_DIGIT_W'(5'd10 - {1'b0, s_item[DIGIT_COUNT].sum});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s_valid[DIGIT_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s_valid[DIGIT_COUNT]) begin
      out_of_range_q <= s_item[DIGIT_COUNT].oor;
      if (s_item[DIGIT_COUNT].oor) begin
        number_valid_q   <= 1'b0;
        expected_digit_q <= '0;
      end else begin
        number_valid_q   <= (expect_d == s_item[DIGIT_COUNT].chk);
        expected_digit_q <= expect_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign number_valid_o   = number_valid_q;
  assign out_of_range_o   = out_of_range_q;
  assign expected_digit_o = expected_digit_q;

endmodule

`default_nettype wire

### dv/luhn_nine_digit_id_check_tb.sv
// testbench for the nine-digit mod 10 id check: range registers, check digit, handshakes
module luhn_nine_digit_id_check_tb;
  import lndc_pkg::*;

  localparam int unsigned RESULT_LATENCY = LNDC_DIGIT_COUNT + 2;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned ID_TOP         = 999999999;

  typedef struct packed {
    logic                    number_valid;
    logic                    out_of_range;
    logic [LNDC_DIGIT_W-1:0] expected_digit;
  } id_verdict_t;

  logic                      clk_i              = 1'b0;
  logic                      rst_ni             = 1'b0;
  logic                      cfg_we_i           = 1'b0;
  logic [LNDC_CFG_IDX_W-1:0] cfg_index_i        = LNDC_CFG_LOWEST;
  logic [LNDC_NUM_W-1:0]     cfg_data_i         = '0;
  logic                      in_valid_i         = 1'b0;
  logic                      in_stall_o;
  logic [LNDC_NUM_W-1:0]     candidate_number_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i        = 1'b0;
  logic                      number_valid_o;
  logic                      out_of_range_o;
  logic [LNDC_DIGIT_W-1:0]   expected_digit_o;

  // copy of the range registers as the block should hold them
  logic [LNDC_NUM_W-1:0] lowest_model  = LNDC_LOWEST_RST;
  logic [LNDC_NUM_W-1:0] highest_model = LNDC_HIGHEST_RST;

  id_verdict_t pending_verdicts[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          send_eager  = 1'b0;
  bit          take_eager  = 1'b0;

  luhn_nine_digit_id_check dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .candidate_number_i (candidate_number_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .number_valid_o     (number_valid_o),
    .out_of_range_o     (out_of_range_o),
    .expected_digit_o   (expected_digit_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // check digit from the leading digits, only the low DIGIT_COUNT digits count
  function automatic logic [LNDC_DIGIT_W-1:0] luhn_check_digit(input longint unsigned num);
    longint unsigned span;
    longint unsigned rest;
    int unsigned     d;
    int unsigned     sum;
    int              p;
    span = 1;
    for (p = 0; p < LNDC_DIGIT_COUNT; p++) span = span * 10;
    rest = (num % span) / 10;
    sum  = 0;
    // position 1 sits next to the check digit and is doubled, then every other one
    for (p = 1; p < LNDC_DIGIT_COUNT; p++) begin
      d    = 32'(rest % 10);
      rest = rest / 10;
      if (p % 2 == 1) begin
        d = 2 * d;
        d = d / 10 + d % 10;
      end
      sum += d;
    end
    return LNDC_DIGIT_W'((10 - sum % 10) % 10);
  endfunction

  function automatic id_verdict_t predict_verdict(input logic [LNDC_NUM_W-1:0] num);
    id_verdict_t v;
    v = '0;
    if (num < lowest_model || num > highest_model) begin
      v.out_of_range = 1'b1;
      return v;
    end
    v.expected_digit = luhn_check_digit(64'(num));
    v.number_valid   = (v.expected_digit == LNDC_DIGIT_W'(num % 10));
    return v;
  endfunction

  function automatic logic [LNDC_NUM_W-1:0] with_check_digit(input int unsigned num);
    return LNDC_NUM_W'(num - num % 10 + luhn_check_digit(64'(num)));
  endfunction

  function automatic int unsigned draw_wait(input bit eager);
    return eager ? 0 : $urandom_range(0, 10);
  endfunction

  // random candidate shaped around the current window
  function automatic logic [LNDC_NUM_W-1:0] pick_candidate();
    int unsigned           r;
    int unsigned           x;
    logic [LNDC_NUM_W-1:0] base;
    r = $urandom_range(0, 99);
    x = $urandom_range(int'(highest_model), int'(lowest_model));
    if (r < 45) return with_check_digit(x);
    if (r < 70) return LNDC_NUM_W'(x);
    if (r < 80) begin
      base = $urandom_range(0, 1) ? lowest_model : highest_model;
      return base + LNDC_NUM_W'($urandom_range(0, 6)) - LNDC_NUM_W'(3);
    end
    if (r < 90) return LNDC_NUM_W'($urandom);
    // check digit off by one
    return LNDC_NUM_W'(x - x % 10 + (luhn_check_digit(64'(x)) + 1) % 10);
  endfunction

  task automatic send_request(input logic [LNDC_NUM_W-1:0] num);
    int unsigned gap;
    gap = draw_wait(send_eager);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    candidate_number_i <= num;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    pending_verdicts.push_back(predict_verdict(num));
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_range(input logic [LNDC_NUM_W-1:0] lo, input logic [LNDC_NUM_W-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= LNDC_CFG_LOWEST;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    lowest_model = lo;
    cfg_index_i <= LNDC_CFG_HIGHEST;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    highest_model = hi;
    cfg_we_i <= 1'b0;
  endtask

  // receiver: stall a drawn number of cycles, then take one result
  initial begin
    int unsigned hold;
    forever begin
      hold = draw_wait(take_eager);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // a result is taken at the next edge when valid is up and stall is down
  always @(negedge clk_i) begin
    id_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (number_valid_o !== want.number_valid) begin
          $error("number_valid: expected %0d, got %0d", want.number_valid, number_valid_o);
          fail_count++;
        end
        if (out_of_range_o !== want.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", want.out_of_range, out_of_range_o);
          fail_count++;
        end
        if (expected_digit_o !== want.expected_digit) begin
          $error("expected_digit: expected %0d, got %0d", want.expected_digit,
                 expected_digit_o);
          fail_count++;
        end
      end
    end
  end

  // reset range, field extremes, digit folding
  task automatic test_reset_defaults();
    send_request('0);
    send_request('1);
    send_request(LNDC_NUM_W'(LNDC_LOWEST_RST - 1));
    send_request(LNDC_LOWEST_RST);
    send_request(LNDC_HIGHEST_RST);
    send_request(LNDC_NUM_W'(LNDC_HIGHEST_RST + 1));
    send_request(with_check_digit(123456780));
    send_request(with_check_digit(999999990));
    send_request(with_check_digit(909090900));
    send_request(LNDC_NUM_W'(123456781));
  endtask

  // widest window, single-number window, inverted window
  task automatic test_range_extremes();
    logic [LNDC_NUM_W-1:0] only;
    wait_drained();
    write_range('0, LNDC_NUM_W'(ID_TOP));
    send_request('0);
    send_request(LNDC_NUM_W'(ID_TOP));
    send_request(with_check_digit(10));
    send_request(with_check_digit(90909090));
    send_request(LNDC_NUM_W'(ID_TOP + 1));
    wait_drained();
    only = with_check_digit($urandom_range(100000000, 900000000));
    write_range(only, only);
    send_request(only);
    send_request(LNDC_NUM_W'(only - 1));
    send_request(LNDC_NUM_W'(only + 1));
    wait_drained();
    write_range(LNDC_NUM_W'(ID_TOP), '0);
    send_request('0);
    send_request(LNDC_NUM_W'(ID_TOP));
    send_request(with_check_digit(500000000));
  endtask

  task automatic test_random_windows();
    int unsigned           phase;
    int unsigned           n;
    logic [LNDC_NUM_W-1:0] lo;
    logic [LNDC_NUM_W-1:0] hi;
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          lo = '0;
          hi = LNDC_NUM_W'(ID_TOP);
        end
        1: begin
          lo = LNDC_NUM_W'($urandom_range(0, ID_TOP - 100));
          hi = lo + LNDC_NUM_W'($urandom_range(0, 100));
        end
        5: begin
          lo = LNDC_LOWEST_RST;
          hi = LNDC_HIGHEST_RST;
        end
        default: begin
          lo = LNDC_NUM_W'($urandom_range(0, 400000000));
          hi = LNDC_NUM_W'($urandom_range(500000000, ID_TOP));
        end
      endcase
      write_range(lo, hi);
      for (n = 0; n < 300; n++) begin
        if (n % 60 == 0) begin
          send_eager = ($urandom_range(0, 2) == 0);
          take_eager = ($urandom_range(0, 2) == 0);
        end
        // sender holds off until the chain has emptied
        if (n == 150) wait_drained();
        send_request(pick_candidate());
      end
    end
    send_eager = 1'b0;
    take_eager = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_range_extremes();
    test_random_windows();
    wait_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/lndc_pkg.sv
rtl/lndc_cell.sv
rtl/luhn_nine_digit_id_check.sv
dv/luhn_nine_digit_id_check_tb.sv
